// ===== hdl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler package
// Shared constants, request and result types and the slot table entry.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = 6;

	localparam logic [3:0] REQ_ALLOC    = 4'd0;
	localparam logic [3:0] REQ_RUNNABLE = 4'd1;
	localparam logic [3:0] REQ_DISPATCH = 4'd2;
	localparam logic [3:0] REQ_SLEEP    = 4'd3;
	localparam logic [3:0] REQ_WAKEUP   = 4'd4;
	localparam logic [3:0] REQ_KILL     = 4'd5;
	localparam logic [3:0] REQ_EXIT     = 4'd6;
	localparam logic [3:0] REQ_RELEASE  = 4'd7;
	localparam logic [3:0] REQ_QUERY    = 4'd8;

	localparam logic [2:0] ST_UNUSED   = 3'd0;
	localparam logic [2:0] ST_USED     = 3'd1;
	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING  = 3'd4;
	localparam logic [2:0] ST_ZOMBIE   = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [3:0]        req_type;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       channel;
		logic [30:0]       target_id;
	} tss_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] out_slot;
		logic [30:0]       out_id;
		logic [2:0]        out_state;
		logic              out_killed;
		logic [31:0]       out_sched_count;
		logic [6:0]        woken_count;
	} tss_rsp_t;

	typedef struct packed {
		logic [2:0]  state;
		logic [30:0] id;
		logic [31:0] chan;
		logic        killed;
		logic [31:0] sched;
	} tss_entry_t;

endpackage

// ===== hdl/tss_table.sv =====
// ----------------------------------------------------------------------------
// Task slot table
// One synchronous memory of slot entries with registered read data. Entries
// never written since reset read as zero by way of one valid bit per entry.
// ----------------------------------------------------------------------------
module tss_table import tss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output tss_entry_t        rd_data,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  tss_entry_t        wr_data
);

	tss_entry_t       mem [SLOTS];
	tss_entry_t       rd_raw_q;
	logic             rd_vld_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

// ===== hdl/tss_fifo.sv =====
// ----------------------------------------------------------------------------
// Slot queue
// Circular queue of slot numbers in a synchronous memory. Pop data appears
// in the cycle after the pop. A position never written reads as its own
// index, which gives the free list its initial contents of every slot in order.
// ----------------------------------------------------------------------------
module tss_fifo import tss_pkg::*; #(
	parameter bit FILLED = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [SLOT_W-1:0] push_data,
	input  logic              pop,
	output logic [SLOT_W-1:0] pop_data,
	output logic              empty,
	output logic              full
);

	logic [SLOT_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]  pv_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W:0]   cnt_q;
	logic [SLOT_W-1:0] tail;
	logic [SLOT_W-1:0] rd_raw_q;
	logic [SLOT_W-1:0] rd_pos_q;
	logic              rd_vld_q;
	logic              push_ok;
	logic              pop_ok;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (SLOT_W+1)'(SLOTS));
	assign tail    = head_q + cnt_q[SLOT_W-1:0];
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail] <= push_data;
		end
		if (pop_ok) begin
			rd_raw_q <= mem[head_q];
			rd_pos_q <= head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q     <= '0;
			rd_vld_q <= 1'b0;
			head_q   <= '0;
			cnt_q    <= FILLED ? (SLOT_W+1)'(SLOTS) : '0;
		end else begin
			if (push_ok) begin
				pv_q[tail] <= 1'b1;
			end
			if (pop_ok) begin
				rd_vld_q <= pv_q[head_q];
				head_q   <= head_q + 1'b1;
			end
			cnt_q <= cnt_q + (SLOT_W+1)'(push_ok) - (SLOT_W+1)'(pop_ok);
		end
	end

	assign pop_data = rd_vld_q ? rd_raw_q : rd_pos_q;

endmodule

// ===== hdl/fifo_task_slot_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Task slot scheduler
// Slot table with a FIFO free list and a FIFO run queue, one request at a
// time, one result per request.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_ready   in_item  (tss_req_t)
//   out       out_valid / out_ready out_item (tss_rsp_t)
//
// Unknown requests, an empty queue and a kill of id zero go straight to the
// output state; alloc passes through S_ALC, slot requests through S_MOD,
// dispatch through S_DQ and S_MOD, and wakeup and kill scan the table memory,
// one entry per cycle. Reset needs no clearing pass. The next request is taken
// as soon as the result is in the output register; a stalled output holds
// the block only once a further result is ready.
// ----------------------------------------------------------------------------
module fifo_task_slot_scheduler_top import tss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tss_req_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output tss_rsp_t out_item
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ALC  = 3'd1;
	localparam logic [2:0] S_DQ   = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]        state_q, state_d;
	tss_req_t          req_q, req_d;
	logic [SLOT_W-1:0] tgt_q, tgt_d;
	logic [SLOT_W-1:0] scan_q, scan_d;
	logic [6:0]        woken_q, woken_d, woken_n;
	tss_rsp_t          res_q, res_d;
	logic [30:0]       next_id_q, next_id_d;
	logic              out_valid_q;
	tss_rsp_t          out_item_q;
	logic              out_load;

	logic              tbl_rd_en, tbl_wr_en;
	logic [SLOT_W-1:0] tbl_rd_addr, tbl_wr_addr;
	tss_entry_t        tbl_rd_data, tbl_wr_data, upd;
	logic              fq_push, fq_pop, fq_empty, fq_full;
	logic [SLOT_W-1:0] fq_pop_data;
	logic              rq_push, rq_pop, rq_empty, rq_full;
	logic [SLOT_W-1:0] rq_pop_data, rq_push_data;
	logic              last;

	function automatic tss_rsp_t rpt(input logic [SLOT_W-1:0] s, input tss_entry_t e);
		tss_rsp_t r;
		r                 = '0;
		r.out_slot        = s;
		r.out_id          = e.id;
		r.out_state       = e.state;
		r.out_killed      = e.killed;
		r.out_sched_count = e.sched;
		return r;
	endfunction

	tss_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data)
	);

	tss_fifo #(.FILLED(1'b1)) u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_data (tgt_q),
		.pop       (fq_pop),
		.pop_data  (fq_pop_data),
		.empty     (fq_empty),
		.full      (fq_full)
	);

	tss_fifo #(.FILLED(1'b0)) u_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rq_push),
		.push_data (rq_push_data),
		.pop       (rq_pop),
		.pop_data  (rq_pop_data),
		.empty     (rq_empty),
		.full      (rq_full)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign last      = (scan_q == SLOT_W'(SLOTS - 1));
	assign woken_n   = (woken_q == 7'h7F) ? woken_q : woken_q + 7'd1;

	always_comb begin
		state_d      = state_q;
		req_d        = req_q;
		tgt_d        = tgt_q;
		scan_d       = scan_q;
		woken_d      = woken_q;
		res_d        = res_q;
		next_id_d    = next_id_q;
		out_load     = 1'b0;
		tbl_rd_en    = 1'b0;
		tbl_rd_addr  = tgt_q;
		tbl_wr_en    = 1'b0;
		tbl_wr_addr  = tgt_q;
		fq_push      = 1'b0;
		fq_pop       = 1'b0;
		rq_push      = 1'b0;
		rq_pop       = 1'b0;
		rq_push_data = tgt_q;
		upd          = tbl_rd_data;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_d   = in_item;
					res_d   = '0;
					woken_d = '0;
					tgt_d   = in_item.slot;
					scan_d  = '0;
					unique case (in_item.req_type) inside
						REQ_ALLOC: begin
							if (fq_empty) begin
								res_d.status = STAT_EMPTY;
								state_d      = S_OUT;
							end else begin
								fq_pop  = 1'b1;
								state_d = S_ALC;
							end
						end
						REQ_DISPATCH: begin
							if (rq_empty) begin
								res_d.status = STAT_EMPTY;
								state_d      = S_OUT;
							end else begin
								rq_pop  = 1'b1;
								state_d = S_DQ;
							end
						end
						REQ_WAKEUP, REQ_KILL: begin
							if (in_item.req_type == REQ_KILL && in_item.target_id == '0) begin
								res_d.status = STAT_NOTFOUND;
								state_d      = S_OUT;
							end else begin
								tbl_rd_en   = 1'b1;
								tbl_rd_addr = '0;
								state_d     = S_SCAN;
							end
						end
						REQ_RUNNABLE, REQ_SLEEP, REQ_EXIT, REQ_RELEASE, REQ_QUERY: begin
							tbl_rd_en   = 1'b1;
							tbl_rd_addr = in_item.slot;
							state_d     = S_MOD;
						end
						default: begin
							state_d = S_OUT;
						end
					endcase
				end
			end
			S_ALC: begin
				tgt_d       = fq_pop_data;
				upd         = '0;
				upd.state   = ST_USED;
				upd.id      = next_id_q;
				tbl_wr_en   = 1'b1;
				tbl_wr_addr = fq_pop_data;
				next_id_d   = (next_id_q == '1) ? 31'd1 : next_id_q + 31'd1;
				res_d       = rpt(fq_pop_data, upd);
				state_d     = S_OUT;
			end
			S_DQ: begin
				tgt_d       = rq_pop_data;
				tbl_rd_en   = 1'b1;
				tbl_rd_addr = rq_pop_data;
				state_d     = S_MOD;
			end
			S_MOD: begin
				case (req_q.req_type)
					REQ_DISPATCH: begin
						upd.state = ST_RUNNING;
						if (upd.sched != '1) begin
							upd.sched = upd.sched + 32'd1;
						end
					end
					REQ_RUNNABLE: begin
						upd.state = ST_RUNNABLE;
						rq_push   = 1'b1;
					end
					REQ_SLEEP: begin
						upd.chan  = req_q.channel;
						upd.state = ST_SLEEPING;
					end
					REQ_EXIT: begin
						upd.state = ST_ZOMBIE;
					end
					REQ_RELEASE: begin
						if (upd.state != ST_UNUSED) begin
							upd.id     = '0;
							upd.chan   = '0;
							upd.killed = 1'b0;
							upd.state  = ST_UNUSED;
							fq_push    = 1'b1;
						end
					end
					default: begin
					end
				endcase
				tbl_wr_en = 1'b1;
				res_d     = rpt(tgt_q, upd);
				state_d   = S_OUT;
			end
			S_SCAN: begin
				tbl_wr_addr  = scan_q;
				rq_push_data = scan_q;
				if (req_q.req_type == REQ_WAKEUP) begin
					if (scan_q != req_q.slot && upd.state == ST_SLEEPING
							&& upd.chan == req_q.channel) begin
						upd.state = ST_RUNNABLE;
						tbl_wr_en = 1'b1;
						rq_push   = 1'b1;
						woken_d   = woken_n;
					end
					if (last) begin
						res_d             = '0;
						res_d.woken_count = woken_d;
						state_d           = S_OUT;
					end else begin
						tbl_rd_en   = 1'b1;
						tbl_rd_addr = scan_q + 1'b1;
						scan_d      = scan_q + 1'b1;
					end
				end else if (upd.id == req_q.target_id) begin
					upd.killed = 1'b1;
					if (upd.state == ST_SLEEPING) begin
						upd.state = ST_RUNNABLE;
						rq_push   = 1'b1;
					end
					tbl_wr_en = 1'b1;
					res_d     = rpt(scan_q, upd);
					state_d   = S_OUT;
				end else if (last) begin
					res_d        = '0;
					res_d.status = STAT_NOTFOUND;
					state_d      = S_OUT;
				end else begin
					tbl_rd_en   = 1'b1;
					tbl_rd_addr = scan_q + 1'b1;
					scan_d      = scan_q + 1'b1;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		tbl_wr_data = upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_id_q   <= 31'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			next_id_q <= next_id_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		tgt_q   <= tgt_d;
		scan_q  <= scan_d;
		woken_q <= woken_d;
		res_q   <= res_d;
		if (out_load) begin
			out_item_q <= res_q;
		end
	end

`ifndef ASSERT_OFF
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_valid) |=> (state_q == S_IDLE))
		else $error("Scheduler left idle without a request.");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_OUT))
		else $error("Result presented outside the output state.");

	a_run_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> (state_q == S_MOD || state_q == S_SCAN))
		else $error("Run queue pushed from an unexpected state.");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(fq_pop || rq_pop) |-> (state_q == S_IDLE))
		else $error("Queue popped while a request is in progress.");
`endif

endmodule
